>>> rtl/bq_pkg.sv
`timescale 1ns / 1ps

package bq_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int STATE_FRAC_BITS = 8;
  localparam int COEF_FRAC_BITS  = 29;
  localparam int COEF_WIDTH      = 32;
  localparam int DELAY_WIDTH     = SAMPLE_WIDTH + STATE_FRAC_BITS;
  // w + 2*d1 + d2 needs two guard bits, one more for headroom
  localparam int SUM_WIDTH       = DELAY_WIDTH + 3;
  localparam int ACC_WIDTH       = COEF_WIDTH + SUM_WIDTH;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = COEF_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYPASS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B0 = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A1 = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A2 = 2'd3;

  typedef struct packed {
    logic enable;
    logic clear;
  } mac_ctrl_t;

endpackage

>>> rtl/second_order_lowpass_biquad.sv
`timescale 1ns / 1ps
// States per sample: FB1, FB2, WCALC, FF, RND, OUT, or only OUT in bypass; one sample
//   is in work at a time; OUT holds while the output stalls. When filtering, the single
//   shared multiplier is used three times per sample (a1*d1, a2*d2, b0*(w+2*d1+d2)).
// Reset (synchronous, active high): bypass set, coefficients and delay values cleared,
//   no result pending.

module second_order_lowpass_biquad
  import bq_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
  // input sample channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample,
  // output sample channel
  output logic                              filtered_valid,
  input  logic                              filtered_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    filtered
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a sample
  localparam logic [2:0] S_FB1   = 3'd1;  // acc = a1*d1
  localparam logic [2:0] S_FB2   = 3'd2;  // acc += a2*d2
  localparam logic [2:0] S_WCALC = 3'd3;  // round feedback, form and saturate w
  localparam logic [2:0] S_FF    = 3'd4;  // acc = b0*(w + 2*d1 + d2), shift delays
  localparam logic [2:0] S_RND   = 3'd5;  // round and saturate output
  localparam logic [2:0] S_OUT   = 3'd6;  // hand result to the output register

  localparam int FBR_WIDTH  = ACC_WIDTH - COEF_FRAC_BITS;
  localparam int WIDE_WIDTH = FBR_WIDTH + 1;
  localparam int OUT_SHIFT  = COEF_FRAC_BITS + STATE_FRAC_BITS;
  localparam int YR_WIDTH   = ACC_WIDTH - OUT_SHIFT;

  localparam logic signed [ACC_WIDTH-1:0] FB_HALF  = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_WIDTH-1:0] OUT_HALF = ACC_WIDTH'(1) << (OUT_SHIFT - 1);

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration registers
  logic                          bypass;
  logic signed [COEF_WIDTH-1:0]  coef_b0;
  logic signed [COEF_WIDTH-1:0]  coef_a1;
  logic signed [COEF_WIDTH-1:0]  coef_a2;

  // filter state
  logic signed [DELAY_WIDTH-1:0] delay_one;
  logic signed [DELAY_WIDTH-1:0] delay_two;

  // working registers
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [DELAY_WIDTH-1:0]  w_reg;
  logic signed [SAMPLE_WIDTH-1:0] result;

  // shared unit
  mac_ctrl_t                     mac_ctrl;
  logic signed [COEF_WIDTH-1:0]  mac_a;
  logic signed [SUM_WIDTH-1:0]   mac_b;
  logic signed [ACC_WIDTH-1:0]   acc;

  logic sample_take;
  logic out_free;

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  // the output register may be loaded when empty or being emptied this cycle
  assign out_free     = !filtered_valid || !filtered_stall;

  // Feedback rounding: add half an LSB, floor by dropping the coefficient fraction
  logic signed [ACC_WIDTH-1:0]   fb_biased;
  logic signed [FBR_WIDTH-1:0]   fb_rounded;
  logic signed [WIDE_WIDTH-1:0]  w_wide;
  logic                          w_ovf;
  logic signed [DELAY_WIDTH-1:0] w_sat;

  assign fb_biased  = acc + FB_HALF;
  assign fb_rounded = fb_biased[ACC_WIDTH-1:COEF_FRAC_BITS];
  assign w_wide     = WIDE_WIDTH'(signed'({x_reg, {STATE_FRAC_BITS{1'b0}}}))
                    - WIDE_WIDTH'(fb_rounded);
  // overflow when the bits above the delay sign do not all match it
  assign w_ovf      = (w_wide[WIDE_WIDTH-1:DELAY_WIDTH-1] != '0)
                   && (w_wide[WIDE_WIDTH-1:DELAY_WIDTH-1] != '1);
  assign w_sat      = w_ovf ? {w_wide[WIDE_WIDTH-1], {(DELAY_WIDTH-1){~w_wide[WIDE_WIDTH-1]}}}
                            : w_wide[DELAY_WIDTH-1:0];

  // Output rounding and clamp to the sample range
  logic signed [ACC_WIDTH-1:0]    y_biased;
  logic signed [YR_WIDTH-1:0]     y_rounded;
  logic                           y_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  assign y_biased  = acc + OUT_HALF;
  assign y_rounded = y_biased[ACC_WIDTH-1:OUT_SHIFT];
  assign y_ovf     = (y_rounded[YR_WIDTH-1:SAMPLE_WIDTH-1] != '0)
                  && (y_rounded[YR_WIDTH-1:SAMPLE_WIDTH-1] != '1);
  assign y_sat     = y_ovf ? {y_rounded[YR_WIDTH-1], {(SAMPLE_WIDTH-1){~y_rounded[YR_WIDTH-1]}}}
                           : y_rounded[SAMPLE_WIDTH-1:0];

  // Feed-forward sum: numerator is b0 * (1, 2, 1)
  logic signed [SUM_WIDTH-1:0] ff_sum;
  assign ff_sum = SUM_WIDTH'(w_reg) + (SUM_WIDTH'(delay_one) <<< 1) + SUM_WIDTH'(delay_two);

  // Operand selection for the shared multiplier
  always_comb begin
    mac_ctrl = '0;
    mac_a    = coef_b0;
    mac_b    = ff_sum;
    unique case (state)
      S_FB1: begin
        mac_ctrl = '{enable: 1'b1, clear: 1'b1};
        mac_a    = coef_a1;
        mac_b    = SUM_WIDTH'(delay_one);
      end
      S_FB2: begin
        mac_ctrl = '{enable: 1'b1, clear: 1'b0};
        mac_a    = coef_a2;
        mac_b    = SUM_WIDTH'(delay_two);
      end
      S_FF: begin
        mac_ctrl = '{enable: 1'b1, clear: 1'b1};
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  bq_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_take) begin
          state_next = bypass ? S_OUT : S_FB1;
        end
      end
      S_FB1:   state_next = S_FB2;
      S_FB2:   state_next = S_WCALC;
      S_WCALC: state_next = S_FF;
      S_FF:    state_next = S_RND;
      S_RND:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass  <= 1'b1;
      coef_b0 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYPASS:  bypass  <= cfg_data[0];
        REG_COEF_B0: coef_b0 <= cfg_data[COEF_WIDTH-1:0];
        REG_COEF_A1: coef_a1 <= cfg_data[COEF_WIDTH-1:0];
        REG_COEF_A2: coef_a2 <= cfg_data[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Delay line: shift once w is known; bypass never reaches S_FF, so it holds
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (state == S_FF) begin
      delay_two <= delay_one;
      delay_one <= w_reg;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (sample_take) begin
      x_reg  <= sample;
      result <= sample;     // bypass word
    end
    if (state == S_WCALC) begin
      w_reg <= w_sat;
    end
    if (state == S_RND) begin
      result <= y_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      filtered_valid <= 1'b1;
    end else if (!filtered_stall) begin
      filtered_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      filtered <= result;
    end
  end

endmodule

>>> rtl/bq_mac.sv
`timescale 1ns / 1ps

// Shared multiply-accumulate: when enabled, acc <= (clear ? 0 : acc) + a * b
module bq_mac
  import bq_pkg::*;
(
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [COEF_WIDTH-1:0]  op_a,
  input  logic signed [SUM_WIDTH-1:0]   op_b,
  output logic signed [ACC_WIDTH-1:0]   acc
);

  logic signed [ACC_WIDTH-1:0] product;
  logic signed [ACC_WIDTH-1:0] base;

  assign product = ACC_WIDTH'(op_a) * ACC_WIDTH'(op_b);
  assign base    = ctrl.clear ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctrl.enable) begin
      acc <= base + product;
    end
  end

endmodule

>>> rtl/bq_checker.sv
`timescale 1ns / 1ps

module bq_checker
  import bq_pkg::*;
(
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample,
  input logic                           filtered_valid,
  input logic                           filtered_stall,
  input logic signed [SAMPLE_WIDTH-1:0] filtered
);

  logic sample_take;
  assign sample_take = sample_valid && !sample_stall;

  // no word is pending straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !filtered_valid)
    else $error("output word pending after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    filtered_valid && filtered_stall |=> filtered_valid && $stable(filtered))
    else $error("stalled output word changed or dropped");

  // one sample at a time: busy right after taking a sample
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> sample_stall)
    else $error("sample taken while previous still in work");

  // no result can appear in the cycle after a sample is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> !$rose(filtered_valid))
    else $error("result appeared too early");

  // a taken sample has no unknown bits
  a_take_known: assert property (@(posedge clk) disable iff (rst)
    sample_take |-> !$isunknown(sample))
    else $error("sample taken with unknown bits");

endmodule

bind second_order_lowpass_biquad bq_checker u_bq_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .sample         (sample),
  .filtered_valid (filtered_valid),
  .filtered_stall (filtered_stall),
  .filtered       (filtered)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
  import bq_pkg::*;
();

  // Shadow of the filter: its own copy of the registers and delay line,
  // and the queue of filtered words still owed by the block.
  class biquad_shadow;
    logic                          bypass;
    logic signed [COEF_WIDTH-1:0]  b0, a1, a2;
    logic signed [DELAY_WIDTH-1:0] d1, d2;
    logic signed [SAMPLE_WIDTH-1:0] filtered_due[$];
    int                            errors;

    function new();
      bypass = 1'b1;
      b0 = '0;
      a1 = '0;
      a2 = '0;
      d1 = '0;
      d2 = '0;
      errors = 0;
    endfunction

    // add half an LSB, then drop k bits with floor
    function longint round_half_up(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function longint clamp(longint v, int width);
      longint hi, lo;
      hi = (longint'(1) <<< (width - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_BYPASS:  bypass = data[0];
        REG_COEF_B0: b0 = data;
        REG_COEF_A1: a1 = data;
        REG_COEF_A2: a2 = data;
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_WIDTH-1:0] x);
      longint fb, w, acc;
      if (bypass) begin
        filtered_due.push_back(x);
        return;
      end
      fb  = longint'(a1) * longint'(d1) + longint'(a2) * longint'(d2);
      w   = clamp((longint'(x) <<< STATE_FRAC_BITS) - round_half_up(fb, COEF_FRAC_BITS),
                  DELAY_WIDTH);
      acc = longint'(b0) * (w + 2 * longint'(d1) + longint'(d2));
      filtered_due.push_back(SAMPLE_WIDTH'(clamp(
        round_half_up(acc, COEF_FRAC_BITS + STATE_FRAC_BITS), SAMPLE_WIDTH)));
      d2 = d1;
      d1 = DELAY_WIDTH'(w);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task match_filtered(logic signed [SAMPLE_WIDTH-1:0] y);
      logic signed [SAMPLE_WIDTH-1:0] want;
      if (filtered_due.size() == 0) begin
        report($sformatf("filtered word %0d arrived with none owed", y));
        return;
      end
      want = filtered_due.pop_front();
      if (y !== want) report($sformatf("filtered %0d, expected %0d", y, want));
    endtask
  endclass

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]         cfg_data = '0;
  logic                              sample_valid = 1'b0;
  logic                              sample_stall;
  logic signed [SAMPLE_WIDTH-1:0]    sample = '0;
  logic                              filtered_valid;
  logic                              filtered_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0]    filtered;

  biquad_shadow shadow = new();

  // idling knobs, changed per phase; calm switches all idling off
  int gap_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;
  int last_word = 0;

  second_order_lowpass_biquad uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall),
    .filtered       (filtered)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit: far beyond the slowest correct run, even with full-length
  // gaps and stalls on every word.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sample outputs at the falling edge, where everything has settled; the
  // word is taken at the next rising edge with these same values.
  always @(negedge clk) begin
    if (!rst && filtered_valid && !filtered_stall) shadow.match_filtered(filtered);
  end

  // Receiver: stall in random bursts, none once the run is calm.
  initial begin : receiver
    int n;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 10);
        filtered_stall <= 1'b1;
        repeat (n) @(posedge clk);
        filtered_stall <= 1'b0;
      end
    end
  end

  // Write one register; leave the enable high so back-to-back writes need
  // only one assignment per edge. The caller drops it.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow.set_reg(idx, data);
  endtask

  // Program every register. Upper bits of the bypass word are random: only
  // bit 0 counts.
  task automatic program_filter(logic byp, logic [31:0] b0, logic [31:0] a1, logic [31:0] a2);
    write_reg(REG_BYPASS, {$urandom} & ~32'd1 | {31'd0, byp});
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample, with an optional gap in front, and hold it until taken.
  task automatic push_sample(logic signed [SAMPLE_WIDTH-1:0] x);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 10);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= x;
    do @(negedge clk); while (sample_stall);
    @(posedge clk);
    shadow.take_sample(x);
  endtask

  // Drop valid, wait for every owed word, then let the pipeline drain.
  task automatic settle();
    sample_valid <= 1'b0;
    while (shadow.filtered_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly full-range words, some extremes, some smooth walks.
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_word();
    int s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = int'($signed(16'($urandom)));
      5, 6: begin
        case ($urandom_range(0, 3))
          0: s = 32767;
          1: s = -32768;
          2: s = 0;
          default: s = -1;
        endcase
      end
      default: begin
        s = last_word + int'($urandom_range(0, 1024)) - 512;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
      end
    endcase
    last_word = s;
    return SAMPLE_WIDTH'(s);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 2))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  initial begin : stimulus
    int          mode, phase, k;
    logic [31:0] b0, a1, a2;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset: bypass, so words pass through untouched.
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    settle();

    // Butterworth low-pass near fc = fs/10; step up, step down, rest.
    program_filter(1'b0, 32'sd36214000, -32'sd613625000, 32'sd221621000);
    repeat (4) push_sample(16'sh7FFF);
    repeat (2) push_sample(16'sh8000);
    push_sample(16'sh0000);
    settle();

    // Bypass holds the delays; the filter picks up where it left off.
    program_filter(1'b1, 32'sd36214000, -32'sd613625000, 32'sd221621000);
    push_sample(16'sd1234);
    push_sample(16'sh8000);
    settle();
    program_filter(1'b0, 32'sd36214000, -32'sd613625000, 32'sd221621000);
    push_sample(16'sh0000);
    push_sample(16'sh0000);
    settle();

    // Extreme coefficients: drive the delay and the output into saturation.
    program_filter(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    settle();

    // Random phases, 100 words each, the last one with no idling.
    for (phase = 0; phase < 14; phase++) begin
      mode = (phase == 0) ? 2 : $urandom_range(0, 5);
      case (mode)
        1: begin
          b0 = $urandom;
          a1 = $urandom;
          a2 = $urandom;
        end
        2: begin
          b0 = pick_extreme();
          a1 = pick_extreme();
          a2 = pick_extreme();
        end
        3: begin
          // unit DC gain, no feedback: checks rounding of the output alone
          b0 = 32'd1 << (COEF_FRAC_BITS - 2);
          a1 = 32'd0;
          a2 = 32'd0;
        end
        default: begin
          // stable-looking low-pass shapes
          b0 = $urandom_range(0, 32'h0800_0000);
          a1 = 32'd0 - $urandom_range(0, 32'h4000_0000);
          a2 = $urandom_range(0, 32'h1FFF_FFFF);
        end
      endcase
      program_filter(mode == 4, b0, a1, a2);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      calm = (phase == 13);
      for (k = 0; k < 100; k++) push_sample(pick_word());
      settle();
    end

    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
